### rtl/infix_to_postfix_converter_assert.svh
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ITP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ITP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ITP_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ITP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/itp_pkg.sv
package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [1:0] KIND_NUMBER   = 2'd0;
    localparam logic [1:0] KIND_VARIABLE = 2'd1;
    localparam logic [1:0] KIND_OPERATOR = 2'd2;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LAST_FN  = 4'd9;
    localparam logic [3:0] OP_OPEN     = 4'd10;
    localparam logic [3:0] OP_CLOSE    = 4'd11;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  op;
        logic [63:0] bits;
        logic [1:0]  err;
    } t_result;

    typedef struct packed {
        t_result res;
        logic    last;
        logic    done;
    } t_beat;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [3:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } t_status;

    function automatic logic [1:0] rank_of(input logic [3:0] code);
        logic [1:0] r;
        if (code <= 4'd1) begin
            r = 2'd1;
        end else if (code <= 4'd3) begin
            r = 2'd2;
        end else if (code <= OP_LAST_FN) begin
            r = 2'd3;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

### rtl/itp_stack_ram.sv
module itp_stack_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itp_pkg::t_ram_req i_req,
    output logic [3:0]        o_top
);
    import itp_pkg::*;

    logic [3:0] r_mem [STACK_DEPTH];
    logic [3:0] r_rd;
    logic [3:0] r_byp_data;
    logic       r_byp_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd       <= r_mem[i_req.raddr];
        r_byp_data <= i_req.wdata;
    end

    // A read that meets a write to the same entry returns the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else begin
            r_byp_valid <= i_req.we && (i_req.waddr == i_req.raddr);
        end
    end

    assign o_top = r_byp_valid ? r_byp_data : r_rd;

endmodule

### rtl/itp_ctrl.sv
module itp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    input  logic [3:0]        i_code,
    input  logic [63:0]       i_bits,
    input  logic              i_eoe,
    output logic              o_ready,
    input  logic [3:0]        i_top,
    output itp_pkg::t_ram_req o_ram,
    input  logic              i_out_free,
    output logic              o_push,
    output itp_pkg::t_beat    o_beat,
    output itp_pkg::t_status  o_status
);
    import itp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_OP    = 4'b0010,
        S_FLUSH = 4'b0100,
        S_END   = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pend_valid, n_pend_valid;
    t_result          r_pend, n_pend;
    logic [1:0]       r_kind;
    logic [3:0]       r_code;
    logic [63:0]      r_bits;
    logic             r_eoe;

    logic    can_emit;
    logic    do_emit;
    t_result emit_res;
    logic    top_pops;
    t_state  after_op;
    logic    want_push;

    assign o_ready  = (r_state == S_IDLE);
    assign can_emit = !r_pend_valid || i_out_free;
    assign after_op = r_eoe ? S_FLUSH : S_END;
    assign top_pops = (r_count != '0) && (i_top != OP_OPEN)
                      && (rank_of(i_top) >= rank_of(r_code));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        do_emit      = 1'b0;
        emit_res     = '{kind: KIND_NUMBER, op: OP_NONE, bits: '0, err: ERR_NONE};
        want_push    = 1'b0;
        o_push       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_OP;
                end
            end
            S_OP: begin
                priority if (r_kind == KIND_NUMBER || r_kind == KIND_VARIABLE) begin
                    if (can_emit) begin
                        do_emit       = 1'b1;
                        emit_res.kind = r_kind;
                        emit_res.bits = (r_kind == KIND_NUMBER) ? r_bits : '0;
                        n_state       = after_op;
                    end
                end else if (r_kind == KIND_OPERATOR && r_code <= OP_LAST_FN) begin
                    if (top_pops) begin
                        if (can_emit) begin
                            do_emit       = 1'b1;
                            emit_res.kind = KIND_OPERATOR;
                            emit_res.op   = i_top;
                            n_count       = r_count - 1'b1;
                        end
                    end else begin
                        want_push = 1'b1;
                    end
                end else if (r_kind == KIND_OPERATOR && r_code == OP_OPEN) begin
                    want_push = 1'b1;
                end else if (r_kind == KIND_OPERATOR && r_code == OP_CLOSE) begin
                    if (r_count != '0 && i_top != OP_OPEN) begin
                        if (can_emit) begin
                            do_emit       = 1'b1;
                            emit_res.kind = KIND_OPERATOR;
                            emit_res.op   = i_top;
                            n_count       = r_count - 1'b1;
                        end
                    end else if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                        n_state = after_op;
                    end else if (can_emit) begin
                        do_emit      = 1'b1;
                        emit_res.err = ERR_UNMATCHED;
                        n_state      = after_op;
                    end
                end else begin
                    n_state = after_op;
                end

                if (want_push) begin
                    if (r_count == CNT_W'(STACK_DEPTH)) begin
                        if (can_emit) begin
                            do_emit      = 1'b1;
                            emit_res.err = ERR_OVERFLOW;
                            n_state      = after_op;
                        end
                    end else begin
                        n_count = r_count + 1'b1;
                        n_state = after_op;
                    end
                end
            end
            S_FLUSH: begin
                if (r_count == '0) begin
                    n_state = S_END;
                end else if (can_emit) begin
                    do_emit = 1'b1;
                    n_count = r_count - 1'b1;
                    if (i_top == OP_OPEN) begin
                        emit_res.err = ERR_UNCLOSED;
                    end else begin
                        emit_res.kind = KIND_OPERATOR;
                        emit_res.op   = i_top;
                    end
                end
            end
            S_END: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_push       = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The newest result is held back one step so that the final one can carry tlast.
        if (do_emit) begin
            o_push       = r_pend_valid;
            n_pend       = emit_res;
            n_pend_valid = 1'b1;
        end
    end

    assign o_beat.res  = r_pend;
    assign o_beat.last = (r_state == S_END);
    assign o_beat.done = (r_state == S_END) && r_eoe;

    assign o_ram.we    = want_push && (n_count != r_count);
    assign o_ram.waddr = r_count[ADDR_W-1:0];
    assign o_ram.wdata = r_code;
    assign o_ram.raddr = ADDR_W'(n_count - 1'b1);

    assign o_status.idle  = (r_state == S_IDLE);
    assign o_status.count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= i_kind;
            r_code <= i_code;
            r_bits <= i_bits;
            r_eoe  <= i_eoe;
        end
    end

endmodule

### rtl/infix_to_postfix_converter.sv
// Shunting-yard converter: infix tokens in, operands and operators in postfix order out, one
// token per input beat and zero or more result beats per token, the final one marked by tlast.
// Operators wait on a 16-entry stack held in a synchronous RAM with a registered read; the
// top entry is read every cycle and forwarded when it was just written. A token passes the
// idle, operator and end states, and a flushing token also the flush state, which pops the
// entries left on the stack; the single RAM read port sets the one-pop-per-cycle pace while
// the output can take results. Errors (stack overflow, unmatched close, unclosed open) come
// out as result beats with a nonzero error code and zero kind, operator and number.
module infix_to_postfix_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // op_code[3:0], number_bits[67:4], zero fill
    input  logic [1:0]  i_s_axis_tuser,  // token_kind[1:0]
    input  logic        i_s_axis_tlast,  // end_of_expression
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // out_op[3:0], out_number_bits[67:4], zero fill
    output logic [4:0]  o_m_axis_tuser,  // out_kind[1:0], error[3:2], expression_done[4]
    output logic        o_m_axis_tlast   // last
);
    import itp_pkg::*;

    `include "infix_to_postfix_converter_assert.svh"

    t_ram_req   ram_req;
    logic [3:0] top;
    logic       out_free;
    logic       push;
    t_beat      beat;
    t_status    status;
    logic       r_out_valid;
    t_beat      r_out;

    assign out_free = !r_out_valid || i_m_axis_tready;

    itp_stack_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_top   (top)
    );

    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .i_code     (i_s_axis_tdata[3:0]),
        .i_bits     (i_s_axis_tdata[67:4]),
        .i_eoe      (i_s_axis_tlast),
        .o_ready    (o_s_axis_tready),
        .i_top      (top),
        .o_ram      (ram_req),
        .i_out_free (out_free),
        .o_push     (push),
        .o_beat     (beat),
        .o_status   (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= beat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out.res.bits, r_out.res.op};
    assign o_m_axis_tuser  = {r_out.done, r_out.res.err, r_out.res.kind};
    assign o_m_axis_tlast  = r_out.last;

    `ITP_ASSERT_SAME(a_push_has_room, i_clk, i_rst_n,
        r_out_valid && !i_m_axis_tready, !push)
    `ITP_ASSERT_SAME(a_count_bounded, i_clk, i_rst_n,
        1'b1, status.count <= CNT_W'(STACK_DEPTH))
    `ITP_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !status.idle)
    `ITP_ASSERT_SAME(a_error_beat_clean, i_clk, i_rst_n,
        o_m_axis_tvalid && r_out.res.err != ERR_NONE,
        r_out.res.kind == KIND_NUMBER && r_out.res.op == OP_NONE && r_out.res.bits == '0)

endmodule

### tb/tb_infix_to_postfix_converter.sv
`timescale 1ns / 1ps

import itp_pkg::*;

localparam logic [3:0] OP_ADD = 4'd0;
localparam logic [3:0] OP_SUB = 4'd1;
localparam logic [3:0] OP_MUL = 4'd2;
localparam logic [3:0] OP_DIV = 4'd3;
localparam logic [3:0] OP_POW = 4'd4;
localparam logic [3:0] OP_SIN = 4'd5;
localparam logic [3:0] OP_COS = 4'd6;
localparam logic [3:0] OP_TAN = 4'd7;
localparam logic [3:0] OP_ABS = 4'd8;
localparam logic [3:0] OP_LN  = 4'd9;
localparam logic [3:0] OP_FIRST_UNKNOWN = 4'd12;
localparam logic [1:0] KIND_UNKNOWN     = 2'd3;

typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  code;
    logic [63:0] bits;
    logic        eoe;
} t_token;

typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [63:0] bits;
    logic [1:0]  err;
    logic        last;
    logic        done;
} t_postfix_beat;

class postfix_scoreboard;
    t_postfix_beat postfix_due[$];
    logic [3:0]    op_stack[STACK_DEPTH];
    int            op_depth;
    int            errors;
    int            beats_checked;

    function new();
        op_depth      = 0;
        errors        = 0;
        beats_checked = 0;
    endfunction

    function int pending_count();
        return postfix_due.size();
    endfunction

    function int precedence(logic [3:0] code);
        if (code <= OP_SUB) return 1;
        if (code <= OP_DIV) return 2;
        if (code <= OP_LAST_FN) return 3;
        return 0;
    endfunction

    function void add_beat(logic [1:0] kind, logic [3:0] op, logic [63:0] bits,
                           logic [1:0] err);
        t_postfix_beat b;
        b.kind = kind;
        b.op   = op;
        b.bits = bits;
        b.err  = err;
        b.last = 1'b0;
        b.done = 1'b0;
        postfix_due.insert(postfix_due.size(), b);
    endfunction

    function void push_op(logic [3:0] code);
        if (op_depth >= STACK_DEPTH) begin
            add_beat(KIND_NUMBER, OP_NONE, '0, ERR_OVERFLOW);
        end else begin
            op_stack[op_depth] = code;
            op_depth++;
        end
    endfunction

    function void convert_token(t_token t);
        int         first;
        logic [3:0] top;
        first = postfix_due.size();
        if (t.kind == KIND_NUMBER) begin
            add_beat(KIND_NUMBER, OP_NONE, t.bits, ERR_NONE);
        end else if (t.kind == KIND_VARIABLE) begin
            add_beat(KIND_VARIABLE, OP_NONE, '0, ERR_NONE);
        end else if (t.kind == KIND_OPERATOR) begin
            if (t.code <= OP_LAST_FN) begin
                while (op_depth > 0 && op_stack[op_depth-1] != OP_OPEN
                       && precedence(op_stack[op_depth-1]) >= precedence(t.code)) begin
                    add_beat(KIND_OPERATOR, op_stack[op_depth-1], '0, ERR_NONE);
                    op_depth--;
                end
                push_op(t.code);
            end else if (t.code == OP_OPEN) begin
                push_op(t.code);
            end else if (t.code == OP_CLOSE) begin
                while (op_depth > 0 && op_stack[op_depth-1] != OP_OPEN) begin
                    add_beat(KIND_OPERATOR, op_stack[op_depth-1], '0, ERR_NONE);
                    op_depth--;
                end
                if (op_depth > 0) begin
                    op_depth--;
                end else begin
                    add_beat(KIND_NUMBER, OP_NONE, '0, ERR_UNMATCHED);
                end
            end
        end
        if (t.eoe) begin
            while (op_depth > 0) begin
                op_depth--;
                top = op_stack[op_depth];
                if (top == OP_OPEN) begin
                    add_beat(KIND_NUMBER, OP_NONE, '0, ERR_UNCLOSED);
                end else begin
                    add_beat(KIND_OPERATOR, top, '0, ERR_NONE);
                end
            end
        end
        if (postfix_due.size() > first) begin
            postfix_due[postfix_due.size()-1].last = 1'b1;
            postfix_due[postfix_due.size()-1].done = t.eoe;
        end
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                      beats_checked, name, got, want));
        end
    endtask

    task check_beat(t_postfix_beat got);
        t_postfix_beat want;
        if (postfix_due.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with no result pending",
                                      beats_checked));
        end else begin
            want = postfix_due.pop_front();
            compare_field("kind", 64'(got.kind), 64'(want.kind));
            compare_field("op", 64'(got.op), 64'(want.op));
            compare_field("number bits", got.bits, want.bits);
            compare_field("error", 64'(got.err), 64'(want.err));
            compare_field("last", 64'(got.last), 64'(want.last));
            compare_field("expression_done", 64'(got.done), 64'(want.done));
        end
        beats_checked++;
    endtask
endclass

module tb_infix_to_postfix_converter;

    localparam int TOKEN_GOAL    = 170;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = STACK_DEPTH + 8;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;
    logic [4:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    postfix_scoreboard sb = new();
    int burst_left     = 0;
    int tokens_counted = 0;

    infix_to_postfix_converter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand_bits();
        return {$urandom, $urandom};
    endfunction

    // The valid stays high after an accepted beat unless a gap follows, so the next call
    // must come in the same time step or the caller must lower it first.
    task automatic send_token(input logic [1:0] kind, input logic [3:0] code,
                              input logic [63:0] bits, input logic eoe);
        t_token tk;
        int     gap;
        tk.kind = kind;
        tk.code = code;
        tk.bits = bits;
        tk.eoe  = eoe;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, bits, code};
        i_s_axis_tuser  <= kind;
        i_s_axis_tlast  <= eoe;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.convert_token(tk);
        tokens_counted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Nested opens, some behind a function, as deep as the caller asks; STACK_DEPTH + 1 levels pass a full stack.
    task automatic send_deep_nest(input int levels);
        int closes;
        for (int i = 0; i < levels; i++) begin
            if ($urandom_range(0, 1) == 1) begin
                send_token(KIND_OPERATOR, 4'($urandom_range(OP_SIN, OP_LN)), rand_bits(),
                           1'b0);
            end
            send_token(KIND_OPERATOR, OP_OPEN, rand_bits(), 1'b0);
        end
        closes = $urandom_range(0, levels + 1);
        send_token(KIND_VARIABLE, 4'($urandom_range(0, 15)), rand_bits(), closes == 0);
        for (int i = 0; i < closes; i++) begin
            send_token(KIND_OPERATOR, OP_CLOSE, rand_bits(), i == closes - 1);
        end
    endtask

    task automatic send_expression();
        t_token toks[$];
        t_token tk;
        int     open_depth;
        int     operands;
        int     target;
        int     sel;
        bit     want_operand;
        bit     finished;
        open_depth   = 0;
        operands     = 0;
        target       = $urandom_range(1, 6);
        want_operand = 1'b1;
        finished     = 1'b0;
        while (!finished) begin
            tk.bits = rand_bits();
            tk.code = 4'($urandom_range(0, 15));
            tk.eoe  = 1'b0;
            tk.kind = KIND_OPERATOR;
            if (want_operand) begin
                sel = $urandom_range(0, 9);
                if (sel < 2 && open_depth < 4) begin
                    tk.code = OP_OPEN;
                    open_depth++;
                end else if (sel < 4) begin
                    tk.code = 4'($urandom_range(OP_SIN, OP_LN));
                end else begin
                    tk.kind = (sel < 8) ? KIND_NUMBER : KIND_VARIABLE;
                    operands++;
                    want_operand = 1'b0;
                end
            end else if (operands >= target && open_depth > 0
                         && $urandom_range(0, 9) == 0) begin
                finished = 1'b1;
            end else if (open_depth > 0
                         && ($urandom_range(0, 2) == 0 || operands >= target)) begin
                tk.code = OP_CLOSE;
                open_depth--;
            end else if (operands >= target) begin
                finished = 1'b1;
            end else begin
                tk.code = 4'($urandom_range(OP_ADD, OP_POW));
                want_operand = 1'b1;
            end
            if (!finished) toks.insert(toks.size(), tk);
        end
        if ($urandom_range(0, 9) == 0) begin
            tk.kind = KIND_OPERATOR;
            tk.code = OP_CLOSE;
            toks.insert(toks.size(), tk);
        end
        toks[toks.size()-1].eoe = 1'b1;
        foreach (toks[i]) begin
            send_token(toks[i].kind, toks[i].code, toks[i].bits, toks[i].eoe);
        end
    endtask

    initial begin : result_monitor
        t_postfix_beat got;
        int            rx_mode;
        int            mode_left;
        int            hold_left;
        logic          hold_val;
        rx_mode   = 0;
        mode_left = 0;
        hold_left = 0;
        hold_val  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind = o_m_axis_tuser[1:0];
                got.err  = o_m_axis_tuser[3:2];
                got.done = o_m_axis_tuser[4];
                got.op   = o_m_axis_tdata[3:0];
                got.bits = o_m_axis_tdata[67:4];
                got.last = o_m_axis_tlast;
                sb.check_beat(got);
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(40, 160);
            end
            mode_left--;
            case (rx_mode)
                0: begin
                    i_m_axis_tready <= 1'b1;
                end
                1: begin
                    i_m_axis_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if (hold_left == 0) begin
                        hold_val  = ~hold_val;
                        hold_left = hold_val ? $urandom_range(1, 8) : $urandom_range(1, 20);
                    end
                    hold_left--;
                    i_m_axis_tready <= hold_val;
                end
            endcase
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_token(KIND_NUMBER, OP_NONE, 64'h0, 1'b1);
        send_token(KIND_NUMBER, OP_NONE, '1, 1'b1);

        // x + 1 * x ^ 2 - x / 0.5 covers every binary operator and mixed precedence.
        send_token(KIND_VARIABLE, OP_NONE, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_ADD, '0, 1'b0);
        send_token(KIND_NUMBER, OP_NONE, 64'h3FF0_0000_0000_0000, 1'b0);
        send_token(KIND_OPERATOR, OP_MUL, '0, 1'b0);
        send_token(KIND_VARIABLE, OP_NONE, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_POW, '0, 1'b0);
        send_token(KIND_NUMBER, OP_NONE, 64'h4000_0000_0000_0000, 1'b0);
        send_token(KIND_OPERATOR, OP_SUB, '0, 1'b0);
        send_token(KIND_VARIABLE, OP_NONE, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_DIV, '0, 1'b0);
        send_token(KIND_NUMBER, OP_NONE, 64'h3FE0_0000_0000_0000, 1'b1);

        send_token(KIND_OPERATOR, OP_SIN, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_COS, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_TAN, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_ABS, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_LN, '0, 1'b0);
        send_token(KIND_VARIABLE, OP_NONE, '0, 1'b1);

        // A matched pair, then a close with no open left under the stacked plus.
        send_token(KIND_OPERATOR, OP_ADD, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_OPEN, '0, 1'b0);
        send_token(KIND_VARIABLE, OP_NONE, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_CLOSE, '0, 1'b0);
        send_token(KIND_OPERATOR, OP_CLOSE, '0, 1'b1);

        send_token(KIND_OPERATOR, OP_OPEN, '0, 1'b0);
        send_token(KIND_VARIABLE, OP_NONE, '0, 1'b1);

        // Ignored tokens on an empty stack give no beat at all.
        send_token(KIND_UNKNOWN, OP_NONE, '0, 1'b1);
        send_token(KIND_OPERATOR, OP_FIRST_UNKNOWN + 4'd1, '0, 1'b0);
        wait_for_results();

        send_deep_nest(STACK_DEPTH + 1);
        send_expression();
        while (tokens_counted < TOKEN_GOAL) begin
            case ($urandom_range(0, 19))
                14, 15, 16: begin
                    repeat ($urandom_range(1, 4)) begin
                        send_token(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                   rand_bits(), $urandom_range(0, 4) == 0);
                    end
                end
                17, 18: begin
                    send_deep_nest($urandom_range(6, 12));
                end
                19: begin
                    wait_for_results();
                end
                default: begin
                    send_expression();
                end
            endcase
        end
        wait_for_results();

        if (sb.pending_count() != 0) begin
            sb.report_mismatch($sformatf("%0d expected beats never arrived",
                                         sb.pending_count()));
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
